FILE: rtl/core/lcsw_pkg.sv
// ----------------------------------------------------------------------------
// lcsw_pkg
// shared constants, segment tables and image builder for the lcd clock
// segment image writer
// ----------------------------------------------------------------------------
`default_nettype none

package lcsw_pkg;

   localparam int NUM_REGS_DEFAULT = 13;
   localparam int IMG_SLOTS        = 16;
   localparam int REG_INDEX_W      = 4;
   localparam int QUEUE_DEPTH      = 2;

   typedef logic [IMG_SLOTS-1:0][7:0] slot_image_type;

   // register/mask pair: register number in [11:8], bit mask in [7:0]
   typedef logic [15:0] seg_pos_type;

   // segment order per digit: top, upper-left, upper-right, middle,
   // lower-left, lower-right, bottom
   localparam seg_pos_type DIGIT_POS [4][7] = '{
      '{16'h0B10, 16'h0801, 16'h0780, 16'h0408, 16'h0101, 16'h0040, 16'h0080},
      '{16'h0B20, 16'h0804, 16'h0802, 16'h0440, 16'h0104, 16'h0410, 16'h0102},
      '{16'h0B80, 16'h0810, 16'h0808, 16'h0501, 16'h0110, 16'h0480, 16'h0108},
      '{16'h0C02, 16'h0904, 16'h0820, 16'h0540, 16'h0204, 16'h0502, 16'h0120}
   };

   // outer bars, happy mouth, right eye, twinkle, four stars
   localparam seg_pos_type ICON_POS [8] = '{
      16'h0002, 16'h0A80, 16'h0704, 16'h0340,
      16'h0402, 16'h0020, 16'h0010, 16'h0B01
   };

   localparam seg_pos_type COLON_POS = 16'h0B40;

   function automatic logic [6:0] digit_shape(input logic [3:0] value);
      logic [6:0] shape;
      case (value)
         4'd0: shape = 7'h77;
         4'd1: shape = 7'h24;
         4'd2: shape = 7'h5D;
         4'd3: shape = 7'h6D;
         4'd4: shape = 7'h2E;
         4'd5: shape = 7'h6B;
         4'd6: shape = 7'h7B;
         4'd7: shape = 7'h25;
         4'd8: shape = 7'h7F;
         4'd9: shape = 7'h6F;
         default: shape = 7'h00;
      endcase
      return shape;
   endfunction

   // tens of a 6-bit value: reciprocal multiply, exact below 64
   function automatic logic [3:0] tens_of(input logic [5:0] value);
      logic [13:0] prod;
      prod = 14'(value) * 14'd205;
      return 4'(prod[13:11]);
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] value);
      logic [5:0] rem;
      rem = value - 6'(tens_of(value)) * 6'd10;
      return rem[3:0];
   endfunction

   function automatic slot_image_type build_image(input logic [4:0] hours,
                                                  input logic [5:0] minutes,
                                                  input logic [5:0] seconds);
      slot_image_type img;
      logic [3:0]     digit [4];
      logic [6:0]     shape;
      img      = '0;
      digit[0] = units_of(minutes);
      digit[1] = tens_of(minutes);
      digit[2] = units_of({1'b0, hours});
      digit[3] = tens_of({1'b0, hours});
      for (int d = 0; d < 4; d++) begin
         shape = digit_shape(digit[d]);
         for (int s = 0; s < 7; s++) begin
            if (shape[s]) begin
               img[DIGIT_POS[d][s][11:8]] = img[DIGIT_POS[d][s][11:8]]
                                            | DIGIT_POS[d][s][7:0];
            end
         end
      end
      for (int i = 0; i < 8; i++) begin
         img[ICON_POS[i][11:8]] = img[ICON_POS[i][11:8]] | ICON_POS[i][7:0];
      end
      if (!seconds[0]) begin
         img[COLON_POS[11:8]] = img[COLON_POS[11:8]] | COLON_POS[7:0];
      end
      return img;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcd_clock_segment_image_writer.sv
// ----------------------------------------------------------------------------
// lcd_clock_segment_image_writer
// turns time samples into minimal register writes for a segment lcd clock
// ----------------------------------------------------------------------------
// Each beat on the req_ channel is one time sample (hours, minutes, seconds).
// The block draws four seven-segment digits (minute units, minute tens, hour
// units, hour tens), the always-on icons and a colon that is lit on even
// seconds into an image of NUM_REGS eight-bit lcd registers. Only registers
// that differ from the image last written come out on the rsp_ channel, one
// beat each, lowest register first, with rsp_last_write set on the final beat
// of the sample; a sample that changes nothing gives no beat at all. Tens and
// units of out-of-range values are value/10 and value%10, so every digit
// still shows a numeral. The front builds the image in the accept cycle
// and drops it into a two-entry queue; the back loads an image and diffs
// it against the written copy, then gives one beat per changed register,
// holding each beat while rsp_stall is high. Only twelve registers carry
// segments (register 6 and any above 12 stay dark), so a sample gives at
// most twelve beats. The queue lets up to two further samples be taken
// while the back is still writing. After reset the written image is all
// zero, so the first sample writes every register that has a lit segment.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_clock_segment_image_writer #(
   parameter int NUM_REGS = lcsw_pkg::NUM_REGS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // time sample channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [4:0]                        req_hours,
   input  wire logic [5:0]                        req_minutes,
   input  wire logic [5:0]                        req_seconds,
   // register write channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [lcsw_pkg::REG_INDEX_W-1:0]       rsp_reg_index,
   output logic [7:0]                             rsp_reg_value,
   output logic                                   rsp_last_write
);

   // front to queue
   logic                     push;
   logic [NUM_REGS-1:0][7:0] push_image;
   logic                     queue_full;

   // queue to back
   logic                     queue_valid;
   logic                     queue_pop;
   logic [NUM_REGS-1:0][7:0] queue_image;

   // front: accept and draw the full image
   lcsw_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_hours   (req_hours),
      .req_minutes (req_minutes),
      .req_seconds (req_seconds),
      .queue_full  (queue_full),
      .push        (push),
      .push_image  (push_image)
   );

   // decouples sample intake from the write stream
   lcsw_queue #(
      .NUM_REGS (NUM_REGS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_image (push_image),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_image  (queue_image)
   );

   // back: diff against written image, one write beat per changed register
   lcsw_back #(
      .NUM_REGS (NUM_REGS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_valid    (queue_valid),
      .queue_image    (queue_image),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_index  (rsp_reg_index),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_last_write (rsp_last_write)
   );

endmodule

`default_nettype wire

FILE: rtl/core/lcsw_front.sv
// ----------------------------------------------------------------------------
// lcsw_front
// takes time samples and turns each into a full segment image for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module lcsw_front #(
   parameter int NUM_REGS = lcsw_pkg::NUM_REGS_DEFAULT
) (
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [4:0]                req_hours,
   input  wire logic [5:0]                req_minutes,
   input  wire logic [5:0]                req_seconds,
   input  wire logic                      queue_full,
   output logic                           push,
   output logic [NUM_REGS-1:0][7:0]       push_image
);

   lcsw_pkg::slot_image_type full_image;

   assign full_image = lcsw_pkg::build_image(req_hours, req_minutes, req_seconds);
   assign push_image = full_image[NUM_REGS-1:0];
   assign req_stall  = queue_full;
   assign push       = req_valid && !queue_full;

endmodule

`default_nettype wire

FILE: rtl/core/lcsw_queue.sv
// ----------------------------------------------------------------------------
// lcsw_queue
// short image queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lcsw_queue #(
   parameter int NUM_REGS = lcsw_pkg::NUM_REGS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [NUM_REGS-1:0][7:0]  push_image,
   output logic                           full,
   input  wire logic                      pop,
   output logic                           pop_valid,
   output logic [NUM_REGS-1:0][7:0]       pop_image
);

   localparam int PTR_W = $clog2(lcsw_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(lcsw_pkg::QUEUE_DEPTH + 1);

   logic [NUM_REGS-1:0][7:0] entry_ff [lcsw_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     do_push, do_pop;

   assign full      = (count_ff == CNT_W'(lcsw_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_image = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lcsw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lcsw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_image;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/lcsw_back.sv
// ----------------------------------------------------------------------------
// lcsw_back
// diffs each image against the written image and issues one write per
// changed register, lowest register first
// ----------------------------------------------------------------------------
`default_nettype none

module lcsw_back #(
   parameter int NUM_REGS = lcsw_pkg::NUM_REGS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 queue_valid,
   input  wire logic [NUM_REGS-1:0][7:0]             queue_image,
   output logic                                      queue_pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [lcsw_pkg::REG_INDEX_W-1:0]          rsp_reg_index,
   output logic [7:0]                                rsp_reg_value,
   output logic                                      rsp_last_write
);

   localparam int IDX_W = $clog2(NUM_REGS);

   logic [NUM_REGS-1:0][7:0]           written_ff, written_in;
   logic [NUM_REGS-1:0][7:0]           image_ff;
   logic [NUM_REGS-1:0]                pending_ff, pending_in;
   logic [NUM_REGS-1:0]                diff;
   logic [NUM_REGS-1:0]                lowest;
   logic [IDX_W-1:0]                   idx;
   logic                               load, emit, out_free;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lcsw_pkg::REG_INDEX_W-1:0]   rsp_index_ff;
   logic [7:0]                         rsp_value_ff;
   logic                               rsp_last_ff;

   // changed registers of the image at the queue head
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         diff[i] = (queue_image[i] != written_ff[i]);
      end
   end

   // isolate lowest pending register and encode it
   assign lowest = pending_ff & (~pending_ff + 1'b1);

   always_comb begin
      idx = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (lowest[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (pending_ff == '0) && queue_valid;
   assign emit      = (pending_ff != '0) && out_free;
   assign queue_pop = load;

   always_comb begin
      written_in   = written_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         written_in = queue_image;
         pending_in = diff;
      end else if (emit) begin
         pending_in = pending_ff & ~lowest;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         written_ff   <= written_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         image_ff <= queue_image;
      end
      if (emit) begin
         rsp_index_ff <= lcsw_pkg::REG_INDEX_W'(idx);
         rsp_value_ff <= image_ff[idx];
         rsp_last_ff  <= ((pending_ff & ~lowest) == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_index  = rsp_index_ff;
   assign rsp_reg_value  = rsp_value_ff;
   assign rsp_last_write = rsp_last_ff;

endmodule

`default_nettype wire

FILE: dv/tb_lcd_clock_segment_image_writer.sv
// ----------------------------------------------------------------------------
// tb_lcd_clock_segment_image_writer
// self-checking bench for the segment lcd clock image writer
// ----------------------------------------------------------------------------
// Time samples go in on the req_ channel. An independent model redraws the
// 13-register segment image for every accepted sample. It diffs that image
// against its own copy of the image last written and queues one expected
// register write per changed register, with the final one flagged. Every
// rsp_ beat is checked against the oldest queued write.
// Stimulus starts with a directed set: the reset image, a repeated sample,
// the colon toggle, out-of-range times, each numeral in each units digit and
// each reachable numeral in each tens digit. After that come mostly ticking
// clock runs, some across minute, hour and midnight rollovers, mixed with
// repeats and full-range noise. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------

module tb_lcd_clock_segment_image_writer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS    = lcsw_pkg::NUM_REGS_DEFAULT;
   localparam int IDX_W       = lcsw_pkg::REG_INDEX_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 4 * NUM_REGS + 8;

   // segment locations: register number in [11:8], bit mask in [7:0]
   // digit order: minute units, minute tens, hour units, hour tens
   // segment order: top, upper-left, upper-right, middle, lower-left,
   // lower-right, bottom
   localparam logic [15:0] SEGMENT_MAP [4][7] = '{
      '{16'h0B10, 16'h0801, 16'h0780, 16'h0408, 16'h0101, 16'h0040, 16'h0080},
      '{16'h0B20, 16'h0804, 16'h0802, 16'h0440, 16'h0104, 16'h0410, 16'h0102},
      '{16'h0B80, 16'h0810, 16'h0808, 16'h0501, 16'h0110, 16'h0480, 16'h0108},
      '{16'h0C02, 16'h0904, 16'h0820, 16'h0540, 16'h0204, 16'h0502, 16'h0120}
   };

   // icons that are always lit: outer bars, mouth, eye, twinkle, four stars
   localparam logic [15:0] ICON_MAP [8] = '{
      16'h0002, 16'h0A80, 16'h0704, 16'h0340,
      16'h0402, 16'h0020, 16'h0010, 16'h0B01
   };

   localparam logic [15:0] COLON_MAP = 16'h0B40;

   // lit segments per numeral, bit 0 = top ... bit 6 = bottom
   localparam logic [6:0] NUMERAL_GLYPH [10] = '{
      7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
   };

   typedef struct packed {
      logic [IDX_W-1:0] reg_num;
      logic [7:0]       value;
      logic             is_last;
   } lcd_write_type;

   // ------------------------------------------------------------------------
   // register write predictor and checker
   // ------------------------------------------------------------------------
   class lcd_write_board;
      logic [7:0]    shown_image [16];
      lcd_write_type due_writes [$];
      int            errors;

      function new();
         foreach (shown_image[i]) shown_image[i] = 8'h00;
         errors = 0;
      endfunction

      // draw the image for one accepted sample and queue the writes it needs
      function void note_sample(logic [4:0] hours, logic [5:0] minutes,
                                logic [5:0] seconds);
         logic [7:0]    img [16];
         int            numeral [4];
         int            n_writes;
         logic [15:0]   loc;
         lcd_write_type wr;
         foreach (img[i]) img[i] = 8'h00;
         numeral[0] = int'(minutes) % 10;
         numeral[1] = int'(minutes) / 10;
         numeral[2] = int'(hours) % 10;
         numeral[3] = int'(hours) / 10;
         for (int d = 0; d < 4; d++) begin
            for (int s = 0; s < 7; s++) begin
               if (NUMERAL_GLYPH[numeral[d]][s]) begin
                  loc = SEGMENT_MAP[d][s];
                  img[loc[11:8]] = img[loc[11:8]] | loc[7:0];
               end
            end
         end
         for (int i = 0; i < 8; i++) begin
            loc = ICON_MAP[i];
            img[loc[11:8]] = img[loc[11:8]] | loc[7:0];
         end
         // colon lights on even seconds
         if (!seconds[0]) begin
            img[COLON_MAP[11:8]] = img[COLON_MAP[11:8]] | COLON_MAP[7:0];
         end
         n_writes = 0;
         for (int r = 0; r < NUM_REGS && r < 16; r++) begin
            if (img[r] != shown_image[r]) begin
               shown_image[r] = img[r];
               wr.reg_num = IDX_W'(r);
               wr.value   = img[r];
               wr.is_last = 1'b0;
               due_writes.push_back(wr);
               n_writes++;
            end
         end
         if (n_writes > 0) due_writes[due_writes.size() - 1].is_last = 1'b1;
      endfunction

      function void check_write(logic [IDX_W-1:0] reg_num, logic [7:0] value,
                                logic is_last);
         lcd_write_type want;
         if (due_writes.size() == 0) begin
            $display("%0t: unexpected write beat reg %0d value %02h last %0b",
                     $time, reg_num, value, is_last);
            errors++;
         end else begin
            want = due_writes.pop_front();
            if (reg_num !== want.reg_num) begin
               $display("%0t: reg_index expected %0d actual %0d",
                        $time, want.reg_num, reg_num);
               errors++;
            end
            if (value !== want.value) begin
               $display("%0t: reg_value (reg %0d) expected %02h actual %02h",
                        $time, want.reg_num, want.value, value);
               errors++;
            end
            if (is_last !== want.is_last) begin
               $display("%0t: last_write (reg %0d) expected %0b actual %0b",
                        $time, want.reg_num, want.is_last, is_last);
               errors++;
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, dut
   // ------------------------------------------------------------------------
   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [4:0]          req_hours      = '0;
   logic [5:0]          req_minutes    = '0;
   logic [5:0]          req_seconds    = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [IDX_W-1:0]    rsp_reg_index;
   logic [7:0]          rsp_reg_value;
   logic                rsp_last_write;

   lcd_write_board      board = new();
   int                  idle_pct  = 0;    // sender gap odds per cycle
   int                  stall_pct = 0;    // receiver stall odds per cycle
   int                  cycle_count = 0;

   // wall clock kept by the ticking runs, and the last sample sent
   int                  clk_h, clk_m, clk_s;
   logic [4:0]          last_h;
   logic [5:0]          last_m, last_s;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   lcd_clock_segment_image_writer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hours      (req_hours),
      .req_minutes    (req_minutes),
      .req_seconds    (req_seconds),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_index  (rsp_reg_index),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_last_write (rsp_last_write)
   );

   // ------------------------------------------------------------------------
   // receive side: check accepted beats, then pick the next stall
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_write(rsp_reg_index, rsp_reg_value, rsp_last_write);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d writes still due", $time,
                  board.due_writes.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // send side
   // ------------------------------------------------------------------------
   // one time sample beat; valid is only lowered for a real gap so it is
   // never dropped and raised within one step
   task automatic send_sample(input logic [4:0] h, input logic [5:0] m,
                              input logic [5:0] s);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_hours   <= h;
      req_minutes <= m;
      req_seconds <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(h, m, s);
      last_h = h;
      last_m = m;
      last_s = s;
   endtask

   // hold off the sender until every queued write has come out
   task automatic drain_writes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.due_writes.size() != 0) @(posedge clock);
   endtask

   // advance the wall clock by one second with carries
   task automatic tick_second();
      clk_s++;
      if (clk_s == 60) begin
         clk_s = 0;
         clk_m++;
         if (clk_m == 60) begin
            clk_m = 0;
            clk_h = (clk_h + 1) % 24;
         end
      end
   endtask

   task automatic directed_samples();
      send_sample(5'd0, 6'd0, 6'd0);      // first sample after reset, full image
      send_sample(5'd0, 6'd0, 6'd0);      // same image, no writes
      send_sample(5'd0, 6'd0, 6'd1);      // colon goes dark
      send_sample(5'd0, 6'd0, 6'd2);      // colon back on
      send_sample(5'd23, 6'd59, 6'd58);
      send_sample(5'd31, 6'd63, 6'd63);   // all fields at their top code
      send_sample(5'd31, 6'd63, 6'd63);
      send_sample(5'd0, 6'd0, 6'd0);      // every bit falls back
      // every units numeral and reachable tens numeral, out-of-range tens too
      send_sample(5'd10, 6'd10, 6'd2);
      send_sample(5'd11, 6'd21, 6'd3);
      send_sample(5'd12, 6'd32, 6'd4);
      send_sample(5'd13, 6'd43, 6'd5);
      send_sample(5'd24, 6'd54, 6'd6);
      send_sample(5'd25, 6'd55, 6'd7);
      send_sample(5'd16, 6'd16, 6'd8);
      send_sample(5'd27, 6'd27, 6'd9);
      send_sample(5'd18, 6'd38, 6'd10);
      send_sample(5'd29, 6'd49, 6'd11);
      send_sample(5'd30, 6'd60, 6'd12);
      send_sample(5'd21, 6'd1, 6'd32);
      send_sample(5'd22, 6'd2, 6'd62);
      send_sample(5'd9, 6'd9, 6'd33);
      send_sample(5'd23, 6'd59, 6'd59);   // rolls to midnight next
      send_sample(5'd0, 6'd0, 6'd0);
   endtask

   // mostly well-formed ticking runs, some repeats and full-range noise
   task automatic random_samples(input int count);
      int n;
      int pick;
      int run;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            clk_h = $urandom_range(23);
            clk_m = $urandom_range(59);
            clk_s = $urandom_range(59);
            // park some runs just short of a rollover
            if ($urandom_range(2) == 0) begin
               clk_m = 59;
               clk_s = $urandom_range(59, 50);
               if ($urandom_range(1) == 0) clk_h = 23;
            end
            run = $urandom_range(30, 5);
            for (int k = 0; k < run && n < count; k++) begin
               send_sample(5'(clk_h), 6'(clk_m), 6'(clk_s));
               tick_second();
               n++;
            end
         end else if (pick < 82) begin
            send_sample(last_h, last_m, last_s);
            n++;
         end else begin
            send_sample(5'($urandom_range(31)), 6'($urandom_range(63)),
                        6'($urandom_range(63)));
            n++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // no gaps, no stalls
      idle_pct  = 0;
      stall_pct = 0;
      directed_samples();
      random_samples(60);
      drain_writes();

      // sender gaps only
      idle_pct  = 53;
      stall_pct = 0;
      random_samples(75);
      drain_writes();

      // receiver stalls only
      idle_pct  = 0;
      stall_pct = 53;
      random_samples(75);
      drain_writes();

      // light gaps on both sides
      idle_pct  = 16;
      stall_pct = 16;
      random_samples(75);

      stall_pct = 0;
      drain_writes();
      repeat (SETTLE) @(posedge clock);

      if (board.errors == 0 && board.due_writes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
